/* rtl/alpha_over_pixel_blend_defines.svh */
// Assertion macros for the alpha-over pixel blend block.
`ifndef ALPHA_OVER_PIXEL_BLEND_DEFINES_SVH
`define ALPHA_OVER_PIXEL_BLEND_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define AOPB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aopb assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define AOPB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aopb assertion failed");

`endif

/* rtl/aopb_pkg.sv */
// Types, constants and helper functions for the alpha-over pixel blend.
package aopb_pkg;

  localparam int unsigned NUM_CH        = 3;
  localparam int unsigned NUM_STAGES    = 6;
  localparam int unsigned QUO_W         = 9;
  localparam int unsigned DIV_PER_STAGE = 3;
  localparam int unsigned DIV_STAGES    = QUO_W / DIV_PER_STAGE;

  localparam logic [7:0]  CH_MAX  = 8'd255;
  localparam logic [15:0] RECIP16 = 16'h8081;   // x/255 = (x*RECIP16)>>23, x < 2^16
  localparam logic [23:0] RECIP24 = 24'h808081; // x/255 = (x*RECIP24)>>31, x < 2^24

  typedef logic [7:0]  chan_t;
  typedef logic [31:0] pixel_t;

  typedef struct packed {
    logic [16:0]      rem;
    logic [QUO_W-1:0] quo;
  } div_t;

  // Channel c of a pixel: 0 red, 1 green, 2 blue.
  function automatic chan_t get_chan(pixel_t p, int unsigned c);
    return p[(NUM_CH - 1 - c) * 8 +: 8];
  endfunction

  // Restoring division, DIV_PER_STAGE quotient bits from bit hi downward.
  function automatic div_t div_steps(div_t d, chan_t oa, int unsigned hi);
    div_t        r;
    logic [16:0] dv;
    r = d;
    for (int j = 0; j < DIV_PER_STAGE; j++) begin
      dv = 17'(oa) << (hi - j);
      if (r.rem >= dv) begin
        r.rem = r.rem - dv;
        r.quo[4'(hi - j)] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

/* rtl/aopb_if.sv */
// Valid/ready channel interfaces for the alpha-over pixel blend.
interface aopb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_pixel;
  logic [31:0] dst_pixel;
  modport source (output valid, output src_pixel, output dst_pixel, input ready);
  modport sink (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

interface aopb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_pixel;
  modport source (output valid, output out_pixel, input ready);
  modport sink (input valid, input out_pixel, output ready);
endinterface

/* rtl/alpha_over_pixel_blend.sv */
// Straight-alpha source-over blend of two ARGB8888 pixels, one word per clock.
// Channels: operand carries src_pixel and dst_pixel; result carries out_pixel.
// Both are valid/ready; a word moves on a clock edge with valid and ready high.
// The first of the six stages loads on the operand edge; bypass cases run the
// same stages. Throughput is one word per clock while result is not stalled.
// The six pipeline registers are: alpha product, /255 reciprocal multiplies,
// then a restoring divider by out alpha that resolves three quotient bits in
// each of its three stages.
// Each stage has its own valid bit and advances when it is empty or the
// stage after it advances, so bubbles are squeezed out under a stall.
// When result is stalled with all six stages full, operand.ready drops;
// nothing is lost or repeated. rst (synchronous) clears all valid bits;
// the data registers are not reset.
`include "alpha_over_pixel_blend_defines.svh"

module alpha_over_pixel_blend (
  input logic        clk,
  input logic        rst,
  aopb_in_if.sink    operand,
  aopb_out_if.source result
);
  import aopb_pkg::*;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || result.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign operand.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= operand.valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: bypass decode, da*(255-sa)
  chan_t       sa_in, da_in;
  logic        s1_byp;
  pixel_t      s1_bpix, s1_src, s1_dst;
  logic [15:0] s1_f;

  assign sa_in = operand.src_pixel[31:24];
  assign da_in = operand.dst_pixel[31:24];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_byp  <= (sa_in == CH_MAX) || (sa_in == '0) || (da_in == '0);
      s1_bpix <= (sa_in != CH_MAX && sa_in == '0) ? operand.dst_pixel : operand.src_pixel;
      s1_src  <= operand.src_pixel;
      s1_dst  <= operand.dst_pixel;
      s1_f    <= 16'(da_in) * 16'(8'(CH_MAX - sa_in));
    end
  end

  // stage 2: out alpha, sc*sa, dc*f
  logic [31:0] fq_prod;
  logic        s2_byp;
  pixel_t      s2_bpix;
  chan_t       s2_oa;
  logic [15:0] s2_sp [NUM_CH];
  logic [23:0] s2_pr [NUM_CH];

  assign fq_prod = 32'(s1_f) * 32'(RECIP16);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_byp  <= s1_byp;
      s2_bpix <= s1_bpix;
      s2_oa   <= s1_src[31:24] + fq_prod[30:23];
      for (int c = 0; c < NUM_CH; c++) begin
        s2_sp[c] <= 16'(get_chan(s1_src, c)) * 16'(s1_src[31:24]);
        s2_pr[c] <= 24'(get_chan(s1_dst, c)) * 24'(s1_f);
      end
    end
  end

  // stage 3: numerator = sc*sa + (dc*f)/255
  logic [47:0] pr_prod [NUM_CH];
  logic        s3_byp;
  pixel_t      s3_bpix;
  chan_t       s3_oa;
  logic [16:0] s3_num [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      pr_prod[c] = 48'(s2_pr[c]) * 48'(RECIP24);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_byp  <= s2_byp;
      s3_bpix <= s2_bpix;
      s3_oa   <= s2_oa;
      for (int c = 0; c < NUM_CH; c++) begin
        s3_num[c] <= 17'(s2_sp[c]) + 17'(pr_prod[c][46:31]);
      end
    end
  end

  // stages 4..6: numerator / out alpha, three quotient bits per stage
  div_t   dq    [DIV_STAGES][NUM_CH];
  chan_t  doa   [DIV_STAGES];
  logic   dbyp  [DIV_STAGES];
  pixel_t dbpix [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    div_t   d_in [NUM_CH];
    chan_t  oa_in;
    logic   byp_in;
    pixel_t bpix_in;

    if (k == 0) begin : g_first
      always_comb begin
        oa_in   = s3_oa;
        byp_in  = s3_byp;
        bpix_in = s3_bpix;
        for (int c = 0; c < NUM_CH; c++) begin
          d_in[c].rem = s3_num[c];
          d_in[c].quo = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        oa_in   = doa[k-1];
        byp_in  = dbyp[k-1];
        bpix_in = dbpix[k-1];
        for (int c = 0; c < NUM_CH; c++) begin
          d_in[c] = dq[k-1][c];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[3+k]) begin
        doa[k]   <= oa_in;
        dbyp[k]  <= byp_in;
        dbpix[k] <= bpix_in;
        for (int c = 0; c < NUM_CH; c++) begin
          dq[k][c] <= div_steps(d_in[c], oa_in, QUO_W - 1 - DIV_PER_STAGE * k);
        end
      end
    end
  end

  localparam int unsigned LAST = DIV_STAGES - 1;

  assign result.valid     = vld[NUM_STAGES-1];
  assign result.out_pixel = dbyp[LAST] ? dbpix[LAST] :
                            {doa[LAST], dq[LAST][0].quo[7:0], dq[LAST][1].quo[7:0],
                             dq[LAST][2].quo[7:0]};

  logic rem_ok;

  assign rem_ok = (dq[LAST][0].rem < 17'(doa[LAST])) &&
                  (dq[LAST][1].rem < 17'(doa[LAST])) &&
                  (dq[LAST][2].rem < 17'(doa[LAST]));

  `AOPB_ASSERT_NXT(a_accept_fills_s1, operand.valid && operand.ready, vld[0])
  `AOPB_ASSERT_IMP(a_stall_only_full, !operand.ready, &vld)
  `AOPB_ASSERT_IMP(a_divisor_nonzero, vld[2] && !s3_byp, s3_oa != '0)
  `AOPB_ASSERT_IMP(a_rem_below_oa, vld[NUM_STAGES-1] && !dbyp[LAST], rem_ok)

endmodule
